/* hw/rtl/cfsd_pkg.sv */
package cfsd_pkg;

  // Frame header layout, in bytes from the start of the header.
  localparam logic [31:0] FrameMagic      = 32'h4353_4631;
  localparam logic [31:0] FrameVersion    = 32'd1;
  localparam int unsigned HeaderBytes     = 60;
  localparam logic [5:0]  MagicLastIdx    = 6'd3;
  localparam logic [5:0]  WideStartIdx    = 6'd8;
  localparam logic [5:0]  TailStartIdx    = 6'd48;
  localparam logic [5:0]  LengthStartIdx  = 6'd56;
  localparam logic [5:0]  HeaderLastIdx   = 6'(HeaderBytes - 1);
  localparam int unsigned NumWideWords    = 5;
  localparam int unsigned NumNarrowWords  = 4;
  localparam logic [31:0] MaxPayloadReset = 32'd65536;

  // Request codes on the input channel.
  localparam logic ReqByte  = 1'b0;
  localparam logic ReqClear = 1'b1;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_HEADER      = 3'd0,
    KIND_PAYLOAD     = 3'd1,
    KIND_BAD_MAGIC   = 3'd2,
    KIND_BAD_VERSION = 3'd3,
    KIND_TOO_LARGE   = 3'd4
  } kind_e;

  // Parser phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_ERROR   = 3'b100
  } phase_e;

  // One result beat.
  typedef struct packed {
    kind_e       kind;
    logic [63:0] account_id;
    logic [63:0] role_id;
    logic [63:0] zone_id;
    logic [63:0] session_id;
    logic [63:0] sequence_number;
    logic [31:0] route_svc;
    logic [31:0] route_op;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        frame_last;
  } result_t;

endpackage

/* hw/rtl/cfsd_parser.sv */
module cfsd_parser
  import cfsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  input  logic [31:0] max_payload_i,
  output logic        res_valid_o,
  output result_t     res_o
);

  phase_e      phase_q, phase_d;
  logic [5:0]  count_q, count_d;
  logic [63:0] wide_q   [NumWideWords];
  logic [63:0] wide_d   [NumWideWords];
  logic [31:0] narrow_q [NumNarrowWords];
  logic [31:0] narrow_d [NumNarrowWords];
  logic [31:0] remain_q, remain_d;

  logic [5:0]  wide_off;
  logic [2:0]  wide_idx;
  logic [1:0]  narrow_idx;
  logic        in_head, in_wide, in_tail;
  logic [31:0] magic_new;
  logic [31:0] length_new;

  // Decode where the current header byte lands.
  assign in_head    = count_q < WideStartIdx;
  assign in_wide    = !in_head && (count_q < TailStartIdx);
  assign in_tail    = !in_head && !in_wide && (count_q < LengthStartIdx);
  assign wide_off   = count_q - WideStartIdx;
  assign wide_idx   = wide_off[5:3];
  assign narrow_idx = {in_tail, count_q[2]};
  assign magic_new  = {narrow_q[0][23:0], data_byte_i};
  assign length_new = {remain_q[23:0], data_byte_i};

  // Next-state and result logic for one beat.
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    remain_d    = remain_q;
    wide_d      = wide_q;
    narrow_d    = narrow_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (accept_i && (req_type_i == ReqClear)) begin
      phase_d  = PH_HEADER;
      count_d  = '0;
      remain_d = '0;
      for (int k = 0; k < NumWideWords; k++) begin
        wide_d[k] = '0;
      end
      for (int k = 0; k < NumNarrowWords; k++) begin
        narrow_d[k] = '0;
      end
    end else if (accept_i) begin
      case (phase_q)
        PH_HEADER: begin
          // Shift the byte into the word it belongs to.
          for (int k = 0; k < NumWideWords; k++) begin
            if (in_wide && (wide_idx == 3'(k))) begin
              wide_d[k] = {wide_q[k][55:0], data_byte_i};
            end
          end
          for (int k = 0; k < NumNarrowWords; k++) begin
            if ((in_head || in_tail) && (narrow_idx == 2'(k))) begin
              narrow_d[k] = {narrow_q[k][23:0], data_byte_i};
            end
          end
          if (!in_head && !in_wide && !in_tail) begin
            remain_d = length_new;
          end
          count_d = count_q + 6'd1;

          if (count_q == MagicLastIdx) begin
            if (magic_new != FrameMagic) begin
              res_valid_o      = 1'b1;
              res_o.kind       = KIND_BAD_MAGIC;
              res_o.frame_last = 1'b1;
              phase_d          = PH_ERROR;
            end
          end else if (count_q == HeaderLastIdx) begin
            res_valid_o = 1'b1;
            if (narrow_q[1] != FrameVersion) begin
              res_o.kind       = KIND_BAD_VERSION;
              res_o.frame_last = 1'b1;
              phase_d          = PH_ERROR;
            end else if (length_new > max_payload_i) begin
              res_o.kind       = KIND_TOO_LARGE;
              res_o.frame_last = 1'b1;
              phase_d          = PH_ERROR;
            end else begin
              res_o.kind            = KIND_HEADER;
              res_o.account_id      = wide_q[0];
              res_o.role_id         = wide_q[1];
              res_o.zone_id         = wide_q[2];
              res_o.session_id      = wide_q[3];
              res_o.sequence_number = wide_q[4];
              res_o.route_svc       = narrow_q[2];
              res_o.route_op        = narrow_q[3];
              res_o.payload_length  = length_new;
              res_o.frame_last      = (length_new == '0);
              count_d               = '0;
              phase_d               = (length_new == '0) ? PH_HEADER : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          // Pass the byte on and count down the payload.
          remain_d           = remain_q - 32'd1;
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_PAYLOAD;
          res_o.payload_byte = data_byte_i;
          res_o.frame_last   = (remain_d == '0);
          if (remain_d == '0) begin
            phase_d = PH_HEADER;
            count_d = '0;
          end
        end
        default: begin
          // Error phase drops bytes until a clear beat.
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      count_q  <= '0;
      remain_q <= '0;
      for (int k = 0; k < NumWideWords; k++) begin
        wide_q[k] <= '0;
      end
      for (int k = 0; k < NumNarrowWords; k++) begin
        narrow_q[k] <= '0;
      end
    end else begin
      phase_q  <= phase_d;
      count_q  <= count_d;
      remain_q <= remain_d;
      wide_q   <= wide_d;
      narrow_q <= narrow_d;
    end
  end

endmodule

/* hw/rtl/cfsd_outbuf.sv */
module cfsd_outbuf
  import cfsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    main_valid_q, skid_valid_q;
  result_t main_q, skid_q;
  logic    out_fire;

  assign out_fire    = main_valid_q && !out_stall_i;
  assign full_o      = skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_q;

  // Valid flags of the output register and the skid stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (main_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        main_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      main_valid_q <= 1'b0;
    end
  end

  // Result data; no reset needed.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        main_q <= skid_q;
      end
    end else if (push_i) begin
      if (main_valid_q && !out_fire) begin
        skid_q <= push_data_i;
      end else begin
        main_q <= push_data_i;
      end
    end
  end

endmodule

/* hw/rtl/client_frame_stream_deframer.sv */
// Length-prefixed frame deframer for a client byte stream.
// Input channel: one beat per stream byte (req_type_i = 0) or a clear beat
// (req_type_i = 1) that returns the parser to the start of a header and
// leaves the error state. A beat is taken when in_valid_i is high and
// in_stall_o is low. Each frame starts with a 60-byte big-endian header:
// magic, version, five 64-bit ids, route service, route method and payload
// length; the payload bytes follow.
// Output channel: a header beat per good header, one beat per payload byte,
// or one error beat (bad magic at header byte 4, bad version or oversize
// length at byte 60), after which bytes are dropped until a clear beat.
// frame_last_o marks the final beat of a frame and every error beat.
// Results are registered; one beat is taken per cycle while in_stall_o is
// low, set by the single parser stage. A two-entry output buffer lets the
// block take one more beat while the receiver stalls; in_stall_o rises
// only when both entries hold. Configuration: max_payload_bytes is written
// through cfg_valid_i / cfg_data_i; the user must write it only while the
// block is idle, which the block does not enforce. Reset sets it to 65536
// and puts the parser at the start of a header with no output pending.
module client_frame_stream_deframer
  import cfsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [63:0] account_id_o,
  output logic [63:0] role_id_o,
  output logic [63:0] zone_id_o,
  output logic [63:0] session_id_o,
  output logic [63:0] sequence_number_o,
  output logic [31:0] route_svc_o,
  output logic [31:0] route_op_o,
  output logic [31:0] payload_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        frame_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] max_payload_q;
  logic        in_accept;
  logic        res_valid;
  result_t     res;
  result_t     out_data;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Payload length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_payload_q <= cfg_data_i;
    end
  end

  cfsd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .req_type_i    (req_type_i),
    .data_byte_i   (data_byte_i),
    .max_payload_i (max_payload_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  cfsd_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  // Unpack the result beat onto the field ports.
  assign kind_o            = out_data.kind;
  assign account_id_o      = out_data.account_id;
  assign role_id_o         = out_data.role_id;
  assign zone_id_o         = out_data.zone_id;
  assign session_id_o      = out_data.session_id;
  assign sequence_number_o = out_data.sequence_number;
  assign route_svc_o       = out_data.route_svc;
  assign route_op_o        = out_data.route_op;
  assign payload_length_o  = out_data.payload_length;
  assign payload_byte_o    = out_data.payload_byte;
  assign frame_last_o      = out_data.frame_last;

  // The skid entry only fills while the output register holds a beat.
  a_stall_needs_output: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> out_valid_o
  ) else $error("input stalled with an empty output register");

  // Every error beat closes its frame.
  a_error_is_last: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (kind_o == KIND_BAD_MAGIC || kind_o == KIND_BAD_VERSION ||
                      kind_o == KIND_TOO_LARGE) |-> frame_last_o
  ) else $error("error beat without frame_last");

  // Only header beats carry header fields.
  a_header_fields_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (kind_o != KIND_HEADER) |->
        (payload_length_o == '0) && (account_id_o == '0)
  ) else $error("header fields set on a non-header beat");

  // A header beat marked last announces an empty payload.
  a_payload_last_only_end: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (kind_o == KIND_HEADER) && frame_last_o |->
        (payload_length_o == '0)
  ) else $error("header beat marked last with a nonempty payload");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import cfsd_pkg::*;

  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned StimulusGoal = 1750;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned MaxReports   = 30;
  localparam int unsigned HeaderBits   = HeaderBytes * 8;
  localparam longint unsigned WholeFrame = 64'hFFFF_FFFF_FFFF;

  // How header id and route words are filled.
  localparam int FillRandom = 0;
  localparam int FillZero   = 1;
  localparam int FillOnes   = 2;

  typedef struct {
    logic       req;
    logic [7:0] data;
  } stream_item_t;

  // Clock, reset and the block's inputs, all known from time zero.
  logic        clk_i     = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_req    = ReqByte;
  logic [7:0]  in_data   = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = 32'h0;

  logic        in_stall;
  logic        out_valid;
  logic [2:0]  res_kind;
  logic [63:0] res_account_id;
  logic [63:0] res_role_id;
  logic [63:0] res_zone_id;
  logic [63:0] res_session_id;
  logic [63:0] res_sequence_number;
  logic [31:0] res_route_svc;
  logic [31:0] res_route_op;
  logic [31:0] res_payload_length;
  logic [7:0]  res_payload_byte;
  logic        res_frame_last;
  logic        cfg_ready;

  // Stimulus and expectation stores.
  stream_item_t bytes_to_send[$];
  result_t      beats_due[$];
  logic [31:0]  limit_writes[$];

  // Parser copy used for prediction.
  phase_e      parse_phase;
  logic [5:0]  header_taken;
  logic [63:0] id_words[NumWideWords];
  logic [31:0] short_words[NumNarrowWords];
  logic [31:0] bytes_left;
  logic [31:0] length_limit = MaxPayloadReset;
  logic [31:0] cur_limit    = MaxPayloadReset;

  // Run control and bookkeeping.
  int unsigned src_gap_pct   = 35;
  int unsigned sink_gap_pct  = 35;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int unsigned n_stimulus    = 0;
  int unsigned n_accepted    = 0;
  int unsigned n_clears      = 0;
  int unsigned n_headers     = 0;
  int unsigned n_payload     = 0;
  int unsigned n_error_beats = 0;
  int unsigned n_settings    = 0;
  int unsigned cfg_writes    = 0;
  int unsigned n_mismatches  = 0;

  client_frame_stream_deframer u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .req_type_i        (in_req),
    .data_byte_i       (in_data),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .kind_o            (res_kind),
    .account_id_o      (res_account_id),
    .role_id_o         (res_role_id),
    .zone_id_o         (res_zone_id),
    .session_id_o      (res_session_id),
    .sequence_number_o (res_sequence_number),
    .route_svc_o       (res_route_svc),
    .route_op_o        (res_route_op),
    .payload_length_o  (res_payload_length),
    .payload_byte_o    (res_payload_byte),
    .frame_last_o      (res_frame_last),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_data_i        (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One line per mismatch, with a cap on how many get printed.
  task automatic note_mismatch(input string msg);
    n_mismatches++;
    if (n_mismatches <= MaxReports) begin
      $display("[%0d] mismatch: %s", cycle_count, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %h expected %h", name, got, want));
    end
  endtask

  // Back to the start of a header; the limit is kept.
  task automatic clear_parse_state();
    parse_phase  = PH_HEADER;
    header_taken = '0;
    bytes_left   = '0;
    foreach (id_words[i]) id_words[i] = '0;
    foreach (short_words[i]) short_words[i] = '0;
  endtask

  task automatic expect_error(input kind_e k);
    result_t r;
    r            = '0;
    r.kind       = k;
    r.frame_last = 1'b1;
    beats_due    = {beats_due, r};
    parse_phase  = PH_ERROR;
  endtask

  // Works out the result, if any, of one accepted input beat.
  task automatic predict_beat(input logic req, input logic [7:0] b);
    result_t     r;
    int unsigned c;
    r = '0;
    c = header_taken;
    if (req == ReqClear) begin
      clear_parse_state();
    end else if (parse_phase == PH_HEADER) begin
      // Big-endian shift into the word that this header byte belongs to.
      if (c < WideStartIdx) begin
        short_words[c >> 2] = {short_words[c >> 2][23:0], b};
      end else if (c < TailStartIdx) begin
        id_words[(c - WideStartIdx) >> 3] = {id_words[(c - WideStartIdx) >> 3][55:0], b};
      end else if (c < LengthStartIdx) begin
        short_words[2 + ((c - TailStartIdx) >> 2)] =
            {short_words[2 + ((c - TailStartIdx) >> 2)][23:0], b};
      end else begin
        bytes_left = {bytes_left[23:0], b};
      end
      header_taken = 6'(c + 1);
      if (c == MagicLastIdx && short_words[0] != FrameMagic) begin
        expect_error(KIND_BAD_MAGIC);
      end else if (c == HeaderLastIdx) begin
        // Version is judged before the length.
        if (short_words[1] != FrameVersion) begin
          expect_error(KIND_BAD_VERSION);
        end else if (bytes_left > length_limit) begin
          expect_error(KIND_TOO_LARGE);
        end else begin
          r.kind            = KIND_HEADER;
          r.account_id      = id_words[0];
          r.role_id         = id_words[1];
          r.zone_id         = id_words[2];
          r.session_id      = id_words[3];
          r.sequence_number = id_words[4];
          r.route_svc       = short_words[2];
          r.route_op        = short_words[3];
          r.payload_length  = bytes_left;
          r.frame_last      = (bytes_left == 0);
          header_taken      = '0;
          parse_phase       = (bytes_left == 0) ? PH_HEADER : PH_PAYLOAD;
          beats_due         = {beats_due, r};
        end
      end
    end else if (parse_phase == PH_PAYLOAD) begin
      r.kind         = KIND_PAYLOAD;
      r.payload_byte = b;
      bytes_left     = bytes_left - 1;
      if (bytes_left == 0) begin
        r.frame_last = 1'b1;
        parse_phase  = PH_HEADER;
        header_taken = '0;
      end
      beats_due = {beats_due, r};
    end
  endtask

  // Input driver: presents queued beats, holding each until it is taken.
  always @(posedge clk_i) begin : drive_stream
    stream_item_t item;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_beat(in_req, in_data);
        n_accepted++;
        if (in_req == ReqClear) n_clears++;
      end
      if (!in_valid || !in_stall) begin
        if (bytes_to_send.size() != 0 && $urandom_range(99) >= src_gap_pct) begin
          item = bytes_to_send.pop_front();
          in_valid <= 1'b1;
          in_req   <= item.req;
          in_data  <= item.data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Limit writes; the predictor's copy follows each accepted write.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        length_limit = cfg_data;
        cfg_writes++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (limit_writes.size() != 0) begin
          cfg_valid <= 1'b1;
          cfg_data  <= limit_writes.pop_front();
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted down here.
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      hold_left    <= HoldCycles;
      holds_served <= holds_served + 1;
    end
  end

  // Output monitor: checks each taken beat against the oldest expectation.
  always @(posedge clk_i) begin : check_beats
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          note_mismatch($sformatf("result beat of kind %0d with none expected", res_kind));
        end else begin
          want = beats_due.pop_front();
          check_field("kind", res_kind, want.kind);
          check_field("account_id", res_account_id, want.account_id);
          check_field("role_id", res_role_id, want.role_id);
          check_field("zone_id", res_zone_id, want.zone_id);
          check_field("session_id", res_session_id, want.session_id);
          check_field("sequence_number", res_sequence_number, want.sequence_number);
          check_field("route_svc", res_route_svc, want.route_svc);
          check_field("route_op", res_route_op, want.route_op);
          check_field("payload_length", res_payload_length, want.payload_length);
          check_field("payload_byte", res_payload_byte, want.payload_byte);
          check_field("frame_last", res_frame_last, want.frame_last);
          case (want.kind)
            KIND_HEADER:  n_headers++;
            KIND_PAYLOAD: n_payload++;
            default:      n_error_beats++;
          endcase
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < sink_gap_pct);
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("client_frame_stream_deframer regression: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [HeaderBits-1:0] build_header(input logic [31:0] magic,
                                                         input logic [31:0] version,
                                                         input logic [31:0] len,
                                                         input int fill);
    logic [319:0] ids;
    logic [63:0]  routes;
    case (fill)
      FillZero: begin
        ids    = '0;
        routes = '0;
      end
      FillOnes: begin
        ids    = '1;
        routes = '1;
      end
      default: begin
        ids    = {rand64(), rand64(), rand64(), rand64(), rand64()};
        routes = rand64();
      end
    endcase
    return {magic, version, ids, routes, len};
  endfunction

  task automatic queue_byte(input logic [7:0] b, input bit counted);
    stream_item_t item;
    item.req      = ReqByte;
    item.data     = b;
    bytes_to_send = {bytes_to_send, item};
    if (counted) n_stimulus++;
  endtask

  task automatic queue_clear();
    stream_item_t item;
    item.req      = ReqClear;
    item.data     = 8'($urandom);
    bytes_to_send = {bytes_to_send, item};
    n_stimulus++;
  endtask

  // Bytes sent while the parser is dropping; they do not count as stimulus.
  task automatic queue_dropped(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) queue_byte(8'($urandom), 1'b0);
  endtask

  // Header then random payload, cut short after `cut` bytes if that comes first.
  task automatic queue_frame(input logic [HeaderBits-1:0] hdr, input longint unsigned paylen,
                             input longint unsigned cut);
    longint unsigned total;
    total = HeaderBytes + paylen;
    if (cut < total) total = cut;
    for (int unsigned i = 0; i < total; i++) begin
      if (i < HeaderBytes) queue_byte(hdr[HeaderBits - 1 - 8 * i -: 8], 1'b1);
      else queue_byte(8'($urandom), 1'b1);
    end
  endtask

  function automatic logic [31:0] pick_good_length();
    logic [31:0] len;
    len = $urandom_range(0, 24);
    if ($urandom_range(15) == 0) len = 0;
    if (len > cur_limit) len = cur_limit;
    return len;
  endfunction

  // One random case; every case leaves the parser at the start of a header.
  task automatic queue_random_case();
    int unsigned     pick;
    logic [31:0]     word;
    logic [31:0]     len;
    longint unsigned big;
    pick = $urandom_range(99);
    if (pick < 62 || (pick >= 78 && pick < 85 && cur_limit == '1)) begin
      len = pick_good_length();
      queue_frame(build_header(FrameMagic, FrameVersion, len, FillRandom), len, WholeFrame);
    end else if (pick < 70) begin
      // Bad magic, mostly a single flipped bit.
      word = FrameMagic ^ (32'd1 << $urandom_range(31));
      if ($urandom_range(3) == 0) word = $urandom;
      if (word == FrameMagic) word = ~word;
      queue_frame(build_header(word, FrameVersion, 0, FillRandom), 0, 4);
      queue_dropped($urandom_range(0, 6));
      queue_clear();
    end else if (pick < 78) begin
      word = FrameVersion ^ (32'd1 << $urandom_range(31));
      if ($urandom_range(3) == 0) word = $urandom;
      if (word == FrameVersion) word = 32'd0;
      queue_frame(build_header(FrameMagic, word, $urandom, FillRandom), 0, WholeFrame);
      queue_dropped($urandom_range(0, 6));
      queue_clear();
    end else if (pick < 85) begin
      big = longint'(cur_limit) + 1 + $urandom_range(0, 500);
      if (big > 64'hFFFF_FFFF || $urandom_range(3) == 0) big = 64'hFFFF_FFFF;
      queue_frame(build_header(FrameMagic, FrameVersion, big[31:0], FillRandom), 0,
                  WholeFrame);
      queue_dropped($urandom_range(0, 6));
      queue_clear();
    end else if (pick < 93) begin
      // Frame broken off by a clear, in the header or in the payload.
      len = pick_good_length();
      queue_frame(build_header(FrameMagic, FrameVersion, len, FillRandom), len,
                  $urandom_range(1, HeaderBytes + len - 1));
      queue_clear();
    end else begin
      // Line noise at the start of a header, or a lone clear.
      if ($urandom_range(1) == 0) begin
        for (int unsigned i = $urandom_range(1, 8); i > 0; i--) queue_byte(8'($urandom), 1'b1);
      end
      queue_clear();
    end
  endtask

  task automatic queue_random_until(input int unsigned goal, input bit with_hold);
    while (n_stimulus < goal) queue_random_case();
    if (with_hold) hold_requests++;
  endtask

  // Waits until every beat is sent and answered, plus the block's latency.
  task automatic wait_idle();
    while (bytes_to_send.size() != 0 || in_valid || beats_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic set_limit(input logic [31:0] value);
    wait_idle();
    limit_writes = {limit_writes, value};
    cur_limit = value;
    n_settings++;
    while (cfg_writes != n_settings) @(negedge clk_i);
  endtask

  initial begin
    int unsigned base;
    int unsigned quarter;
    clear_parse_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;

    // Directed cases at the reset limit.
    queue_frame(build_header(FrameMagic, FrameVersion, 0, FillOnes), 0, WholeFrame);
    queue_frame(build_header(FrameMagic, FrameVersion, 3, FillZero), 3, WholeFrame);
    queue_frame(build_header(32'h0053_4631, FrameVersion, 0, FillRandom), 0, 4);
    queue_dropped(2);
    queue_clear();
    queue_frame(build_header(32'h4353_4630, FrameVersion, 0, FillRandom), 0, 4);
    queue_clear();
    queue_frame(build_header(FrameMagic, 32'd0, 5, FillRandom), 0, WholeFrame);
    queue_clear();
    // Bad version together with an oversize length: version wins.
    queue_frame(build_header(FrameMagic, 32'd2, 32'hFFFF_FFFF, FillRandom), 0, WholeFrame);
    queue_clear();
    queue_frame(build_header(FrameMagic, FrameVersion, MaxPayloadReset + 1, FillRandom), 0,
                WholeFrame);
    queue_clear();
    // Length exactly at the limit is accepted.
    queue_frame(build_header(FrameMagic, FrameVersion, MaxPayloadReset, FillRandom),
                MaxPayloadReset, HeaderBytes + 4);
    queue_clear();
    queue_frame(build_header(FrameMagic, FrameVersion, 1, FillRandom), 1, 30);
    queue_clear();
    queue_clear();
    queue_frame(build_header(FrameMagic, FrameVersion, 1, FillRandom), 1, WholeFrame);

    // Limit of zero: only empty frames pass.
    set_limit(32'd0);
    queue_frame(build_header(FrameMagic, FrameVersion, 0, FillRandom), 0, WholeFrame);
    queue_frame(build_header(FrameMagic, FrameVersion, 1, FillRandom), 0, WholeFrame);
    queue_clear();

    // Limit of all ones: the largest length is accepted.
    set_limit(32'hFFFF_FFFF);
    queue_frame(build_header(FrameMagic, FrameVersion, 32'hFFFF_FFFF, FillRandom),
                64'hFFFF_FFFF, HeaderBytes + 3);
    queue_clear();

    // Random phases under several limits, one of them without idling. The
    // remaining stimulus budget is split evenly over the four phases.
    base    = n_stimulus;
    quarter = (StimulusGoal > base) ? (StimulusGoal - base) / 4 : 0;
    set_limit($urandom_range(8, 40));
    queue_random_until(base + quarter, 1'b1);
    set_limit(32'hFFFF_FFFF);
    src_gap_pct  = 0;
    sink_gap_pct = 0;
    queue_random_until(base + 2 * quarter, 1'b0);
    set_limit(32'd0);
    src_gap_pct  = 35;
    sink_gap_pct = 35;
    queue_random_until(base + 3 * quarter, 1'b0);
    set_limit($urandom_range(1, 24));
    queue_random_until(StimulusGoal, 1'b1);
    wait_idle();

    $display("run covered %0d input beats (%0d clears) and %0d result beats: %0d headers,",
             n_accepted, n_clears, n_headers + n_payload + n_error_beats, n_headers);
    $display("  %0d payload bytes, %0d error beats; %0d limit writes, %0d receiver hold-offs",
             n_payload, n_error_beats, n_settings, holds_served);
    if (n_mismatches == 0 && beats_due.size() == 0) begin
      $display("client_frame_stream_deframer regression: pass");
    end else begin
      $display("client_frame_stream_deframer regression: fail");
    end
    $finish;
  end

endmodule
